@@ hw/rtl/rwr_pkg.sv @@
// range window remap package: table size, transaction structs, state codes
// no dependencies; imported by every file of the block except rwr_ram
package rwr_pkg;

    localparam int TABLE_ENTRIES = 64;
    localparam int TBL_AW        = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int TBL_CNT_W     = $clog2(TABLE_ENTRIES + 1);
    localparam int ACTIVE_W      = 7;

    localparam logic REQ_WRITE  = 1'b0;
    localparam logic REQ_LOOKUP = 1'b1;

    typedef struct packed {
        logic        req_type;
        logic [5:0]  entry_index;
        logic [31:0] dest_base;
        logic [31:0] source_base;
        logic [31:0] span_length;
        logic [31:0] lookup_value;
        logic        batch_last;
    } t_req;

    typedef struct packed {
        logic [31:0] mapped_value;
        logic        matched;
        logic        batch_end;
    } t_rsp;

    typedef struct packed {
        logic [31:0] dest;
        logic [31:0] source;
        logic [31:0] length;
    } t_window;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_MAP,
        ST_DONE
    } t_state;

endpackage

@@ hw/rtl/rwr_ram.sv @@
// generic single write port ram with registered read
// no dependencies
module rwr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                         i_clk,
    input  logic                                         i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                             i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                             o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ hw/rtl/range_window_remap_core.sv @@
// range window remap top level: window table, first-match scan sequencer
// depends on rwr_pkg and rwr_ram
//
//  channel | direction | handshake               | payload
//  in      | input     | i_in_valid / o_in_ready | i_in_data  (t_req)
//  out     | output    | o_out_valid/ i_out_ready| o_out_data (t_rsp)
//  cfg     | input     | i_cfg_we                | i_cfg_wdata (active_entries)
//
// a write transaction leaves the input ready; a lookup holds the input until its result is
// in the output register, scanning with one ram read and one compare per window up to the
// first hit or N = searched windows (active_entries, capped at the table size)
// one output register lets the next transaction enter while a result waits; a stalled output
// only holds a finished lookup in its last state
// reset is synchronous and clears control state and active_entries; the table needs no clearing
module range_window_remap_core (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  rwr_pkg::t_req         i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output rwr_pkg::t_rsp         o_out_data,
    input  logic                  i_cfg_we,
    input  logic [6:0]            i_cfg_wdata
);

    import rwr_pkg::*;

    t_state                r_state, n_state;
    logic [TBL_CNT_W-1:0]  r_idx, n_idx;
    logic                  r_pend, n_pend;
    logic [TBL_CNT_W-1:0]  r_limit, n_limit;
    logic [31:0]           r_value, n_value;
    logic                  r_last, n_last;
    logic [31:0]           r_dest, n_dest;
    logic [31:0]           r_diff, n_diff;
    t_rsp                  r_res, n_res;
    t_rsp                  r_out, n_out;
    logic                  r_out_vld, n_out_vld;
    logic [ACTIVE_W-1:0]   r_active, n_active;

    logic                  in_acc;
    logic                  tbl_we;
    logic                  idx_ok;
    logic [TBL_CNT_W-1:0]  lim;
    logic [TBL_AW-1:0]     tbl_raddr;
    t_window               tbl_wdata;
    t_window               tbl_rdata;
    logic [32:0]           win_end;
    logic                  win_hit;

    assign in_acc    = i_in_valid && o_in_ready;
    assign idx_ok    = 32'(i_in_data.entry_index) < 32'(TABLE_ENTRIES);
    assign tbl_we    = in_acc && (i_in_data.req_type == REQ_WRITE) && idx_ok;
    assign tbl_wdata = '{dest:   i_in_data.dest_base,
                         source: i_in_data.source_base,
                         length: i_in_data.span_length};
    assign tbl_raddr = r_idx[TBL_AW-1:0];

    rwr_ram #(
        .WIDTH ($bits(t_window)),
        .DEPTH (TABLE_ENTRIES)
    ) u_tbl (
        .i_clk   (i_clk),
        .i_we    (tbl_we),
        .i_waddr (TBL_AW'(i_in_data.entry_index)),
        .i_wdata (tbl_wdata),
        .i_raddr (tbl_raddr),
        .o_rdata (tbl_rdata)
    );

    assign win_end = {1'b0, tbl_rdata.source} + {1'b0, tbl_rdata.length};
    assign win_hit = (r_value >= tbl_rdata.source) && ({1'b0, r_value} < win_end);

    assign lim = (32'(r_active) > 32'(TABLE_ENTRIES)) ? TBL_CNT_W'(TABLE_ENTRIES)
                                                      : TBL_CNT_W'(r_active);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_pend    <= 1'b0;
            r_out_vld <= 1'b0;
            r_active  <= '0;
        end else begin
            r_state   <= n_state;
            r_pend    <= n_pend;
            r_out_vld <= n_out_vld;
            r_active  <= n_active;
        end
        r_idx   <= n_idx;
        r_limit <= n_limit;
        r_value <= n_value;
        r_last  <= n_last;
        r_dest  <= n_dest;
        r_diff  <= n_diff;
        r_res   <= n_res;
        r_out   <= n_out;
    end

    always_comb begin
        n_state   = r_state;
        n_idx     = r_idx;
        n_pend    = r_pend;
        n_limit   = r_limit;
        n_value   = r_value;
        n_last    = r_last;
        n_dest    = r_dest;
        n_diff    = r_diff;
        n_res     = r_res;
        n_out     = r_out;
        n_out_vld = r_out_vld;
        n_active  = i_cfg_we ? i_cfg_wdata : r_active;
        o_in_ready = 1'b0;

        if (r_out_vld && i_out_ready) begin
            n_out_vld = 1'b0;
        end

        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid && (i_in_data.req_type == REQ_LOOKUP)) begin
                    n_value = i_in_data.lookup_value;
                    n_last  = i_in_data.batch_last;
                    n_limit = lim;
                    n_idx   = '0;
                    n_pend  = 1'b0;
                    if (lim == '0) begin
                        n_res   = '{mapped_value: i_in_data.lookup_value, matched: 1'b0,
                                    batch_end: i_in_data.batch_last};
                        n_state = ST_DONE;
                    end else begin
                        n_state = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                // issue the next read while checking the previous one
                n_pend = r_idx < r_limit;
                if (r_idx < r_limit) begin
                    n_idx = r_idx + 1'b1;
                end
                if (r_pend) begin
                    if (win_hit) begin
                        n_dest  = tbl_rdata.dest;
                        n_diff  = r_value - tbl_rdata.source;
                        n_state = ST_MAP;
                    end else if (r_idx == r_limit) begin
                        n_res   = '{mapped_value: r_value, matched: 1'b0, batch_end: r_last};
                        n_state = ST_DONE;
                    end
                end
            end
            ST_MAP: begin
                n_res   = '{mapped_value: r_dest + r_diff, matched: 1'b1, batch_end: r_last};
                n_state = ST_DONE;
            end
            ST_DONE: begin
                if (!r_out_vld || i_out_ready) begin
                    n_out     = r_res;
                    n_out_vld = 1'b1;
                    n_state   = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

endmodule

@@ hw/rtl/rwr_checker.sv @@
// port level checker for range_window_remap_core, with its bind statement
// depends on rwr_pkg
module rwr_checker (
    input logic            i_clk,
    input logic            i_rst_n,
    input logic            i_in_valid,
    input logic            o_in_ready,
    input rwr_pkg::t_req   i_in_data,
    input logic            o_out_valid,
    input logic            i_out_ready,
    input rwr_pkg::t_rsp   o_out_data
);

    import rwr_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result dropped before transaction");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> $stable(o_out_data))
        else $error("result changed while stalled");

    a_rst_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    a_lookup_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && (i_in_data.req_type == REQ_LOOKUP) |=> !o_in_ready)
        else $error("ready right after lookup transaction");

    a_write_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && (i_in_data.req_type == REQ_WRITE) |=> o_in_ready)
        else $error("write transaction stalled input");

endmodule

bind range_window_remap_core rwr_checker u_rwr_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_in_data   (i_in_data),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);

@@ sim/range_window_remap_checker.sv @@
// range window remap checker: watches the in, out and cfg ports of the core,
// keeps its own window table and predicts every lookup result
// depends on rwr_pkg
module range_window_remap_checker (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic          i_in_ready,
    input  rwr_pkg::t_req i_in_data,
    input  logic          i_out_valid,
    input  logic          i_out_ready,
    input  rwr_pkg::t_rsp i_out_data,
    input  logic          i_cfg_we,
    input  logic [6:0]    i_cfg_wdata,
    output int            o_fail_count,
    output int            o_pending
);
    import rwr_pkg::*;

    t_window    window_tbl [TABLE_ENTRIES];
    logic [6:0] searched_cfg;
    t_rsp       expected_rsp_q [$];
    int         fail_total;

    function automatic t_rsp remap_lookup(input t_req req);
        t_rsp        res;
        int          lim;
        int          i;
        logic [32:0] lo;
        logic [32:0] hi;
        lim = (searched_cfg > TABLE_ENTRIES) ? TABLE_ENTRIES : int'(searched_cfg);
        res.mapped_value = req.lookup_value;
        res.matched      = 1'b0;
        res.batch_end    = req.batch_last;
        // first match wins, window end formed at 33 bits
        for (i = 0; i < lim && !res.matched; i++) begin
            lo = {1'b0, window_tbl[i].source};
            hi = lo + {1'b0, window_tbl[i].length};
            if ({1'b0, req.lookup_value} >= lo && {1'b0, req.lookup_value} < hi) begin
                res.mapped_value = window_tbl[i].dest + (req.lookup_value - window_tbl[i].source);
                res.matched      = 1'b1;
            end
        end
        return res;
    endfunction

    task automatic check_rsp(input t_rsp got);
        t_rsp want;
        if (expected_rsp_q.size() == 0) begin
            $error("unexpected result transaction: mapped_value %h matched %b batch_end %b",
                   got.mapped_value, got.matched, got.batch_end);
            fail_total++;
        end else begin
            want = expected_rsp_q.pop_front();
            if (got.mapped_value !== want.mapped_value) begin
                $error("mapped_value: expected %h, actual %h", want.mapped_value, got.mapped_value);
                fail_total++;
            end
            if (got.matched !== want.matched) begin
                $error("matched: expected %b, actual %b", want.matched, got.matched);
                fail_total++;
            end
            if (got.batch_end !== want.batch_end) begin
                $error("batch_end: expected %b, actual %b", want.batch_end, got.batch_end);
                fail_total++;
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            searched_cfg = '0;
            expected_rsp_q.delete();
        end else begin
            if (i_out_valid && i_out_ready) check_rsp(i_out_data);
            if (i_cfg_we) searched_cfg = i_cfg_wdata;
            if (i_in_valid && i_in_ready) begin
                if (i_in_data.req_type == REQ_WRITE) begin
                    if (i_in_data.entry_index < TABLE_ENTRIES) begin
                        window_tbl[i_in_data.entry_index].dest   = i_in_data.dest_base;
                        window_tbl[i_in_data.entry_index].source = i_in_data.source_base;
                        window_tbl[i_in_data.entry_index].length = i_in_data.span_length;
                    end
                end else begin
                    expected_rsp_q.push_back(remap_lookup(i_in_data));
                end
            end
        end
        o_pending    <= expected_rsp_q.size();
        o_fail_count <= fail_total;
    end

endmodule

@@ sim/range_window_remap_core_tb.sv @@
// range window remap testbench top: clock, reset, stimulus and verdict
// depends on rwr_pkg, range_window_remap_core and range_window_remap_checker
module range_window_remap_core_tb;
    import rwr_pkg::*;

    localparam int RESET_CYCLES   = 11;
    localparam int DRAIN_CYCLES   = 80;
    localparam int HOLD_CYCLES    = 400;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int PHASES         = 8;
    localparam int PHASE_ITEMS    = 210;

    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       in_valid  = 1'b0;
    logic       in_ready;
    t_req       in_data   = '0;
    logic       out_valid;
    logic       out_ready = 1'b0;
    t_rsp       out_data;
    logic       cfg_we    = 1'b0;
    logic [6:0] cfg_wdata = '0;

    int          fail_count;
    int          pending;
    int          idle_pct    = 0;
    int          stall_pct   = 0;
    int          hold_token  = 0;
    int          hold_seen   = 0;
    int          hold_left   = 0;
    int          quiet_cycles = 0;
    int          active_cfg  = 0;
    logic [31:0] cluster_base;
    logic [31:0] shadow_source [TABLE_ENTRIES];
    logic [31:0] shadow_length [TABLE_ENTRIES];
    logic [6:0]  phase_active [PHASES] = '{7'd1, 7'd64, 7'd5, 7'd127, 7'd64, 7'd0, 7'd40, 7'd16};

    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    range_window_remap_core dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata)
    );

    range_window_remap_checker remap_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_in_data    (in_data),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_out_data   (out_data),
        .i_cfg_we     (cfg_we),
        .i_cfg_wdata  (cfg_wdata),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // receiver: random stalls, or a long hold-off when the token moves
    always @(negedge clk) begin
        if (hold_token != hold_seen) begin
            hold_seen <= hold_token;
            hold_left <= HOLD_CYCLES;
            out_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            out_ready <= 1'b0;
        end else begin
            out_ready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    always @(posedge clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    task automatic push_req(input t_req req);
        while ($urandom_range(0, 99) < idle_pct) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= req;
        if (req.req_type == REQ_WRITE) begin
            shadow_source[req.entry_index] = req.source_base;
            shadow_length[req.entry_index] = req.span_length;
        end
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        @(negedge clk);
    endtask

    function automatic t_req random_req();
        t_req req;
        req.req_type     = 1'($urandom_range(0, 1));
        req.entry_index  = 6'($urandom_range(0, TABLE_ENTRIES - 1));
        req.dest_base    = $urandom;
        req.source_base  = $urandom;
        req.span_length  = $urandom;
        req.lookup_value = $urandom;
        req.batch_last   = 1'($urandom_range(0, 1));
        return req;
    endfunction

    task automatic write_window(input logic [5:0] idx, input logic [31:0] dest,
                                input logic [31:0] src, input logic [31:0] len);
        t_req req;
        req             = random_req();
        req.req_type    = REQ_WRITE;
        req.entry_index = idx;
        req.dest_base   = dest;
        req.source_base = src;
        req.span_length = len;
        push_req(req);
    endtask

    task automatic lookup(input logic [31:0] value, input logic last);
        t_req req;
        req              = random_req();
        req.req_type     = REQ_LOOKUP;
        req.lookup_value = value;
        req.batch_last   = last;
        push_req(req);
    endtask

    task automatic random_window(input logic [5:0] idx);
        logic [31:0] src;
        logic [31:0] len;
        case ($urandom_range(0, 9))
            0: begin
                src = $urandom;
                len = 32'h0;
            end
            1: begin
                // window end can pass 2^32
                src = 32'hFFFF_FFFF - $urandom_range(0, 32'hFFFF);
                len = $urandom_range(1, 32'h2_0000);
            end
            2: begin
                src = $urandom;
                len = $urandom;
            end
            default: begin
                // clustered windows so that they overlap
                src = cluster_base + $urandom_range(0, 8191);
                len = $urandom_range(1, 4096);
            end
        endcase
        write_window(idx, $urandom, src, len);
    endtask

    function automatic logic [31:0] aimed_value();
        int          lim;
        int          pick;
        logic [31:0] src;
        logic [31:0] len;
        lim = (active_cfg > TABLE_ENTRIES) ? TABLE_ENTRIES : active_cfg;
        if (lim == 0 || $urandom_range(0, 9) < 2) return $urandom;
        pick = $urandom_range(0, lim - 1);
        src  = shadow_source[pick];
        len  = shadow_length[pick];
        case ($urandom_range(0, 9))
            0:       return src;
            1:       return src + len - 1;
            2:       return src + len;
            3:       return src - 1;
            default: return (len == 0) ? $urandom : src + ($urandom % len);
        endcase
    endfunction

    task automatic set_active(input logic [6:0] count);
        in_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= count;
        @(negedge clk);
        cfg_we     <= 1'b0;
        active_cfg = count;
    endtask

    initial begin
        int i;
        int ph;
        int n;
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        cluster_base = $urandom;

        // nothing searched after reset
        lookup(32'h0000_0000, 1'b0);
        lookup(32'hFFFF_FFFF, 1'b1);

        write_window(6'd0, 32'h1000_0000, 32'h0000_0100, 32'h0000_0100);
        write_window(6'd1, 32'h2000_0000, 32'h0000_0180, 32'h0000_0100);
        write_window(6'd2, 32'h3000_0000, 32'h0000_5000, 32'h0000_0000);
        write_window(6'd3, 32'hFFFF_FFF0, 32'hFFFF_FF00, 32'h0000_0200);
        for (i = 4; i < TABLE_ENTRIES - 1; i++) random_window(6'(i));
        write_window(6'(TABLE_ENTRIES - 1), 32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF);

        set_active(7'd4);
        lookup(32'h0000_0100, 1'b0);
        lookup(32'h0000_01FF, 1'b0);
        lookup(32'h0000_0180, 1'b0);    // overlap, first window wins
        lookup(32'h0000_0200, 1'b0);
        lookup(32'h0000_0280, 1'b0);
        lookup(32'h0000_5000, 1'b0);    // zero length
        lookup(32'hFFFF_FF20, 1'b0);    // destination wraps
        lookup(32'hFFFF_FFFF, 1'b0);
        lookup(32'hFFFF_FEFF, 1'b0);
        lookup(32'h0000_0000, 1'b1);

        // saturates to the table size
        set_active(7'd127);
        lookup(32'hFFFF_FFFF, 1'b0);
        lookup(32'h8000_0000, 1'b0);
        lookup($urandom, 1'b0);
        lookup(32'hFFFF_FFFE, 1'b1);

        set_active(7'd0);
        lookup(32'h0000_0100, 1'b1);

        set_active(7'd1);
        lookup(32'h0000_01FF, 1'b0);
        lookup(32'h0000_0200, 1'b1);

        for (ph = 0; ph < PHASES; ph++) begin
            set_active(phase_active[ph]);
            case (ph % 4)
                0: begin
                    idle_pct = 0;
                    stall_pct <= 0;
                end
                1: begin
                    idle_pct = 50;
                    stall_pct <= 0;
                end
                2: begin
                    idle_pct = 0;
                    stall_pct <= 50;
                end
                default: begin
                    idle_pct = 23;
                    stall_pct <= 23;
                end
            endcase
            // long receiver hold-off while lookups keep coming
            if (ph == 4) hold_token <= hold_token + 1;
            for (n = 0; n < PHASE_ITEMS; n++) begin
                if ($urandom_range(0, 99) < 12) random_window(6'($urandom_range(0, TABLE_ENTRIES - 1)));
                else lookup(aimed_value(), 1'($urandom_range(0, 1)));
            end
        end

        in_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (fail_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
